// ===== hdl/rsgg_pkg.sv =====
// ----------------------------------------------------------------------------
// rsgg_pkg
// Shared types, constants and helpers of the radial sample grid generator.
// ----------------------------------------------------------------------------
package rsgg_pkg;

	// Default parameter values
	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int INDEX_BITS_DEF       = 12;

	// Front-to-back queue, and the stages behind it
	localparam int QUEUE_DEPTH   = 4;
	localparam int BACK_STAGES   = 3;
	localparam int MAX_IN_FLIGHT = QUEUE_DEPTH + BACK_STAGES;

	// Configuration register indexes
	localparam logic [2:0] CFG_GRID_MODE   = 3'd0;
	localparam logic [2:0] CFG_COLUMNS     = 3'd1;
	localparam logic [2:0] CFG_ROWS        = 3'd2;
	localparam logic [2:0] CFG_SLICES      = 3'd3;
	localparam logic [2:0] CFG_STEP_X      = 3'd4;
	localparam logic [2:0] CFG_STEP_Z      = 3'd5;
	localparam logic [2:0] CFG_ANGLE_START = 3'd6;
	localparam logic [2:0] CFG_ANGLE_STEP  = 3'd7;

	// Positions are signed Q2.15 in 18 bits
	localparam logic signed [17:0] POS_HALF_NEG = -18'sd16384;
	localparam logic signed [17:0] POS_MAX      = 18'sd131071;

	// Quarter turn of phase (cos(p) = sin(p + quarter))
	localparam logic [15:0] PHASE_QUARTER = 16'h4000;

	localparam logic [14:0] SINE_MAX = 15'h7FFF;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		MODE_RADIAL_3D  = 2'd0,
		MODE_RADIAL_2D  = 2'd1,
		MODE_UNIFORM_2D = 2'd2
	} grid_mode_t;

	// One grid point as handed from the walker to the arithmetic back end
	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] z;
		logic [15:0]        phase;
		grid_mode_t         mode;
		logic               last;
	} point_t;

	// Saturate a signed 19-bit value to Q0.15
	function automatic logic signed [15:0] sat_q15(input logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767)
			r = 16'sh7FFF;
		else if (v < -19'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// Quarter-wave sine entry from a Q30 angle, seven Taylor correction terms.
	// Evaluated at elaboration only.
	function automatic logic [14:0] sine_from_angle(input longint unsigned t);
		longint unsigned t2;
		longint unsigned term;
		longint          sum;
		longint unsigned v;
		t2   = (t * t) >> 30;
		term = t;
		sum  = longint'(t);
		term = ((term * t2) >> 30) / 6;    sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 20;   sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 42;   sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 72;   sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 110;  sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 156;  sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 210;  sum = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[14:0];
	endfunction

endpackage

// ===== hdl/rsgg_queue.sv =====
// ----------------------------------------------------------------------------
// rsgg_queue
// Small register queue of grid points between the walker and the back end.
// ----------------------------------------------------------------------------
module rsgg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rsgg_pkg::point_t push_point,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rsgg_pkg::point_t pop_point
);
	import rsgg_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	point_t           entry_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (QAW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_point  = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_point;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QAW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QAW+1)'(1);
		end
	end

endmodule

// ===== hdl/rsgg_front.sv =====
// ----------------------------------------------------------------------------
// rsgg_front
// Configuration registers and grid walker: one point per accepted beat.
// ----------------------------------------------------------------------------
module rsgg_front #(
	parameter int INDEX_BITS = rsgg_pkg::INDEX_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             restart,
	output logic             push_valid,
	input  logic             push_ready,
	output rsgg_pkg::point_t push_point
);
	import rsgg_pkg::*;

	// compare width: holds both a 13-bit count and 2^INDEX_BITS
	localparam int CW = (INDEX_BITS + 1 > 13) ? INDEX_BITS + 1 : 13;
	localparam logic [CW-1:0] CAP = CW'(1) << INDEX_BITS;

	logic [1:0]  mode_q;
	logic [12:0] columns_q, rows_q, slices_q;
	logic [15:0] step_x_q, step_z_q, angle_start_q, angle_step_q;

	logic [INDEX_BITS-1:0] col_q, row_q, slice_q;
	logic signed [17:0]    x_q, z_q;
	logic [15:0]           phase_q;

	logic [INDEX_BITS-1:0] col_e, row_e, slice_e;
	logic signed [17:0]    x_e, z_e;
	logic [15:0]           phase_e;
	grid_mode_t            mode;
	logic                  use_rows, use_slices;
	logic                  col_end, row_end, slice_end;
	logic                  accept;

	function automatic logic [CW-1:0] limit_of(input logic [12:0] n);
		logic [CW-1:0] r;
		r = CW'(n);
		if (n == '0)
			r = CW'(1);
		else if (r > CAP)
			r = CAP;
		return r;
	endfunction

	function automatic logic signed [17:0] pos_add(input logic signed [17:0] p,
			input logic [15:0] s);
		logic signed [18:0] sum;
		sum = {p[17], p} + $signed({3'b000, s});
		// step is never negative: only the top can overflow
		return (sum[18] != sum[17]) ? POS_MAX : sum[17:0];
	endfunction

	// Config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RADIAL_3D;
			columns_q     <= 13'd1;
			rows_q        <= 13'd1;
			slices_q      <= 13'd1;
			step_x_q      <= 16'h8000;
			step_z_q      <= 16'h8000;
			angle_start_q <= 16'h0000;
			angle_step_q  <= 16'h0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_MODE:   mode_q        <= cfg_data[1:0];
				CFG_COLUMNS:     columns_q     <= cfg_data[12:0];
				CFG_ROWS:        rows_q        <= cfg_data[12:0];
				CFG_SLICES:      slices_q      <= cfg_data[12:0];
				CFG_STEP_X:      step_x_q      <= cfg_data;
				CFG_STEP_Z:      step_z_q      <= cfg_data;
				CFG_ANGLE_START: angle_start_q <= cfg_data;
				CFG_ANGLE_STEP:  angle_step_q  <= cfg_data;
			endcase
		end
	end

	// Mode decode; the unused code runs as uniform 2D
	always_comb begin
		unique case (mode_q)
			MODE_RADIAL_3D: mode = MODE_RADIAL_3D;
			MODE_RADIAL_2D: mode = MODE_RADIAL_2D;
			default:        mode = MODE_UNIFORM_2D;
		endcase
	end

	assign use_rows   = (mode != MODE_RADIAL_2D);
	assign use_slices = (mode != MODE_UNIFORM_2D);

	// Restart takes effect before this beat's point is formed
	assign col_e   = restart ? '0 : col_q;
	assign row_e   = restart ? '0 : row_q;
	assign slice_e = restart ? '0 : slice_q;
	assign x_e     = restart ? POS_HALF_NEG : x_q;
	assign z_e     = restart ? POS_HALF_NEG : z_q;
	assign phase_e = restart ? angle_start_q : phase_q;

	assign col_end   = (CW'(col_e) + CW'(1)) >= limit_of(columns_q);
	assign row_end   = !use_rows || ((CW'(row_e) + CW'(1)) >= limit_of(rows_q));
	assign slice_end = !use_slices || ((CW'(slice_e) + CW'(1)) >= limit_of(slices_q));

	assign push_point.x     = x_e;
	assign push_point.z     = z_e;
	assign push_point.phase = phase_e;
	assign push_point.mode  = mode;
	assign push_point.last  = col_end && row_end && slice_end;

	assign push_valid = in_valid;
	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;

	// Walk advance: column innermost, slice outermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
			x_q     <= POS_HALF_NEG;
			z_q     <= POS_HALF_NEG;
			phase_q <= 16'h0000;
		end else if (accept) begin
			if (!col_end) begin
				col_q   <= col_e + INDEX_BITS'(1);
				x_q     <= pos_add(x_e, step_x_q);
				row_q   <= row_e;
				z_q     <= z_e;
				slice_q <= slice_e;
				phase_q <= phase_e;
			end else if (!row_end) begin
				col_q   <= '0;
				x_q     <= POS_HALF_NEG;
				row_q   <= row_e + INDEX_BITS'(1);
				z_q     <= pos_add(z_e, step_z_q);
				slice_q <= slice_e;
				phase_q <= phase_e;
			end else if (!slice_end) begin
				col_q   <= '0;
				x_q     <= POS_HALF_NEG;
				row_q   <= '0;
				z_q     <= POS_HALF_NEG;
				slice_q <= slice_e + INDEX_BITS'(1);
				phase_q <= phase_e + angle_step_q;
			end else begin
				col_q   <= '0;
				x_q     <= POS_HALF_NEG;
				row_q   <= '0;
				z_q     <= POS_HALF_NEG;
				slice_q <= '0;
				phase_q <= angle_start_q;
			end
		end
	end

endmodule

// ===== hdl/rsgg_back.sv =====
// ----------------------------------------------------------------------------
// rsgg_back
// Sine/cosine lookup, scaling and saturation; holds the output register.
// ----------------------------------------------------------------------------
module rsgg_back #(
	parameter int SINE_TABLE_DEPTH = rsgg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  rsgg_pkg::point_t   pop_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] coord_a,
	output logic signed [15:0] coord_b,
	output logic signed [15:0] coord_c,
	output logic               last_point
);
	import rsgg_pkg::*;

	localparam int AB = $clog2(SINE_TABLE_DEPTH);      // rom address bits
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);  // index incl. the depth
	localparam int PW = 14 + IW;

	typedef struct packed {
		logic          neg;
		logic          full;
		logic [AB-1:0] addr;
	} lookup_t;

	// Quarter-wave sine rom
	logic [14:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned Angle =
			(longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
		localparam logic [14:0] Entry = sine_from_angle(Angle);
		assign sine_rom[k] = Entry;
	end

	function automatic lookup_t lookup_of(input logic [15:0] ph);
		logic [PW-1:0] prod;
		logic [IW-1:0] i;
		logic [IW-1:0] idx;
		lookup_t       r;
		prod   = PW'(ph[13:0]) * PW'(SINE_TABLE_DEPTH);
		i      = prod[PW-1:14];
		idx    = ph[14] ? (IW'(SINE_TABLE_DEPTH) - i) : i;
		r.neg  = ph[15];
		r.full = (idx == IW'(SINE_TABLE_DEPTH));
		r.addr = r.full ? '0 : idx[AB-1:0];
		return r;
	endfunction

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	lookup_t     look_a, look_b;
	logic [15:0] phase_a, phase_b;

	logic [14:0]        rom_a_s1, rom_b_s1;
	logic               neg_a_s1, neg_b_s1, full_a_s1, full_b_s1;
	logic signed [17:0] x_s1, z_s1;
	grid_mode_t         mode_s1;
	logic               last_s1;

	logic signed [15:0] sin_a, sin_b;
	logic signed [33:0] prod_a_s2, prod_b_s2;
	logic signed [17:0] x_s2, z_s2;
	grid_mode_t         mode_s2;
	logic               last_s2;

	logic signed [33:0] rnd_a, rnd_b;
	logic signed [15:0] a_c, b_c, c_c;

	// Stall chain from the output register back to the queue
	assign en3       = !v_s3 || out_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign pop_ready = en1;

	// Mode 0 puts cos on a, mode 1 puts sin on a
	assign phase_a = (pop_point.mode == MODE_RADIAL_3D) ?
		pop_point.phase + PHASE_QUARTER : pop_point.phase;
	assign phase_b = (pop_point.mode == MODE_RADIAL_3D) ?
		pop_point.phase : pop_point.phase + PHASE_QUARTER;
	assign look_a  = lookup_of(phase_a);
	assign look_b  = lookup_of(phase_b);

	// s1: two rom reads
	always_ff @(posedge clk) begin
		if (en1) begin
			rom_a_s1  <= sine_rom[look_a.addr];
			rom_b_s1  <= sine_rom[look_b.addr];
			neg_a_s1  <= look_a.neg;
			neg_b_s1  <= look_b.neg;
			full_a_s1 <= look_a.full;
			full_b_s1 <= look_b.full;
			x_s1      <= pop_point.x;
			z_s1      <= pop_point.z;
			mode_s1   <= pop_point.mode;
			last_s1   <= pop_point.last;
		end
	end

	// s2: signed sine values and products
	always_comb begin
		sin_a = $signed({1'b0, full_a_s1 ? SINE_MAX : rom_a_s1});
		sin_b = $signed({1'b0, full_b_s1 ? SINE_MAX : rom_b_s1});
		if (neg_a_s1)
			sin_a = -sin_a;
		if (neg_b_s1)
			sin_b = -sin_b;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_a_s2 <= x_s1 * sin_a;
			prod_b_s2 <= x_s1 * sin_b;
			x_s2      <= x_s1;
			z_s2      <= z_s1;
			mode_s2   <= mode_s1;
			last_s2   <= last_s1;
		end
	end

	// s3: round half up to Q15, saturate, select per mode
	assign rnd_a = prod_a_s2 + 34'sd16384;
	assign rnd_b = prod_b_s2 + 34'sd16384;

	always_comb begin
		unique case (mode_s2)
			MODE_RADIAL_3D: begin
				a_c = sat_q15(rnd_a[33:15]);
				b_c = sat_q15(rnd_b[33:15]);
				c_c = sat_q15({z_s2[17], z_s2});
			end
			MODE_RADIAL_2D: begin
				a_c = sat_q15(rnd_a[33:15]);
				b_c = sat_q15(rnd_b[33:15]);
				c_c = '0;
			end
			default: begin
				a_c = sat_q15({x_s2[17], x_s2});
				b_c = sat_q15({z_s2[17], z_s2});
				c_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			coord_a    <= a_c;
			coord_b    <= b_c;
			coord_c    <= c_c;
			last_point <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= pop_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;

endmodule

// ===== hdl/radial_sample_grid_generator.sv =====
// ----------------------------------------------------------------------------
// radial_sample_grid_generator
// Walks a radial or uniform sampling grid and emits one point per beat.
// ----------------------------------------------------------------------------
// Each input beat asks for one point; restart=1 returns the first point of the
// grid, restart=0 the next one. The walk runs slice outermost, then z row,
// then x column, and wraps after the beat flagged last_point. Radial 3D gives
// (x*cos, x*sin, z), radial 2D gives (x*sin, x*cos, 0), uniform 2D gives
// (x, z, 0); all in signed Q0.15, saturated. Throughput is one beat per cycle
// in both directions while out_ready stays high, set by the walker, the two
// read ports of the sine rom and the pair of 18x16 multipliers. An accepted
// input beat is written into the queue, then passes s1, s2 and the output
// register. Up to seven beats may be in flight: a four-entry queue behind
// the walker plus three arithmetic stages, the last being the output
// register, so input beats keep being taken while a result waits. Write the
// configuration only while nothing is in flight; count registers of zero
// act as one, angle_start is picked up at restart or wrap.
// ----------------------------------------------------------------------------
module radial_sample_grid_generator #(
	parameter int SINE_TABLE_DEPTH = rsgg_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int INDEX_BITS       = rsgg_pkg::INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request beats
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	// point beats
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] coord_a,
	output logic signed [15:0] coord_b,
	output logic signed [15:0] coord_c,
	output logic               last_point
);
	import rsgg_pkg::*;

	// walker -> queue
	logic   push_valid;
	logic   push_ready;
	point_t push_point;
	// queue -> arithmetic
	logic   pop_valid;
	logic   pop_ready;
	point_t pop_point;

	// Front: config registers and index/position walk
	rsgg_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_point (push_point)
	);

	// Decoupling queue, lets each side stall on its own
	rsgg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_point (push_point),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_point  (pop_point)
	);

	// Back: trig lookup, scaling, output register
	rsgg_back #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_point  (pop_point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coord_a    (coord_a),
		.coord_b    (coord_b),
		.coord_c    (coord_c),
		.last_point (last_point)
	);

endmodule

// ===== hdl/rsgg_checker.sv =====
// ----------------------------------------------------------------------------
// rsgg_checker
// Port-level checks on the grid generator, bound to the top level.
// ----------------------------------------------------------------------------
module rsgg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] coord_a,
	input logic signed [15:0] coord_b,
	input logic signed [15:0] coord_c,
	input logic               last_point
);
	import rsgg_pkg::*;

	localparam int CNW = $clog2(MAX_IN_FLIGHT + 2);

	// beats taken but not yet delivered
	logic [CNW-1:0] pending_q;
	logic           in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_beat && !out_beat)
			pending_q <= pending_q + CNW'(1);
		else if (out_beat && !in_beat)
			pending_q <= pending_q - CNW'(1);
	end

	// a stalled point holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coord_a) &&
			$stable(coord_b) && $stable(coord_c) && $stable(last_point))
		else $error("output point changed while stalled");

	// no point without a request behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("output point without a pending request");

	// back pressure must stop requests before storage overflows
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNW'(MAX_IN_FLIGHT))
		else $error("more beats in flight than storage holds");

	// an empty block never refuses a request
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> in_ready)
		else $error("request refused while empty");

endmodule

bind radial_sample_grid_generator rsgg_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.coord_a    (coord_a),
	.coord_b    (coord_b),
	.coord_c    (coord_c),
	.last_point (last_point)
);

// ===== sim/tb_radial_sample_grid_generator.sv =====
// ----------------------------------------------------------------------------
// tb_radial_sample_grid_generator
// Self-checking bench for the radial / uniform sample grid generator.
// ----------------------------------------------------------------------------
// Request beats (restart bit) are queued by the stimulus process and driven
// by a valid/ready driver. Each accepted request is run through a local model
// of the grid walk (counters, Q2.15 positions, quarter-wave sine table). The
// model pushes the point it predicts. The monitor checks every point beat
// against the oldest predicted point. Registers are rewritten between phases,
// once nothing is in flight. The phases cover extreme settings, all grid
// modes, the unused mode code, zero and oversize counts, and saturating steps.
// ----------------------------------------------------------------------------
module tb_radial_sample_grid_generator;

	import rsgg_pkg::*;

	localparam int          TABLE_DEPTH = SINE_TABLE_DEPTH_DEF;
	localparam int          COUNT_CAP   = 1 << INDEX_BITS_DEF;
	localparam int          SINE_FULL   = 32767;
	localparam int          CYCLE_LIMIT = 300000;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;   // decodes as uniform 2D

	localparam logic [1:0] MODE_CODES [4] = '{MODE_RADIAL_3D, MODE_RADIAL_2D,
		MODE_UNIFORM_2D, MODE_UNUSED};

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic        last;
	} grid_point_t;

	// DUT pins
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [2:0]         cfg_index  = CFG_GRID_MODE;
	logic [15:0]        cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic               restart    = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic signed [15:0] coord_a;
	logic signed [15:0] coord_b;
	logic signed [15:0] coord_c;
	logic               last_point;

	// register shadow
	logic [1:0] mode_reg;
	int         columns_reg, rows_reg, slices_reg;
	int         step_x_reg, step_z_reg, angle_start_reg, angle_step_reg;

	// walk state of the model
	int          col_i, row_i, slice_i;
	int          x_pos, z_pos;
	logic [15:0] phase_acc;

	int sine_quarter [TABLE_DEPTH];

	// request bits waiting for the driver, and points predicted but not seen
	logic        requests [$];
	grid_point_t points_due [$];
	int          requests_open = 0;   // queued or on the bus, not yet accepted

	// handshake bookkeeping
	bit req_taken     = 1'b0;  // request beat accepted at the last rising edge
	int points_taken  = 0;
	int mismatches    = 0;
	int cycles        = 0;

	// idling
	int send_idle_pct = 20;
	int recv_idle_pct = 20;
	int send_gap      = 0;
	int recv_gap      = 0;
	int hold_left     = 0;
	int holds_done    = 0;

	radial_sample_grid_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coord_a    (coord_a),
		.coord_b    (coord_b),
		.coord_c    (coord_c),
		.last_point (last_point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Grid model
	// ------------------------------------------------------------------

	// Quarter-wave entry: Taylor series in Q30, seven correction terms,
	// then scaled to 32767 with round half up.
	function automatic int quarter_sine(int k);
		longint unsigned ang, sq, term, v;
		longint          acc;
		ang  = (longint'(k) * HALF_PI_Q30) / TABLE_DEPTH;
		sq   = (ang * ang) >> 30;
		term = ang;
		acc  = longint'(ang);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return int'(v);
	endfunction

	// Full-circle sine from a 16-bit phase; odd quadrants mirror the index,
	// the upper half negates. Index equal to the depth reads full scale.
	function automatic int sine_at(logic [15:0] ph);
		int idx, mag;
		idx = int'((longint'(ph[13:0]) * TABLE_DEPTH) >> 14);
		if (ph[14])
			idx = TABLE_DEPTH - idx;
		mag = (idx >= TABLE_DEPTH) ? SINE_FULL : sine_quarter[idx];
		return ph[15] ? -mag : mag;
	endfunction

	function automatic logic [15:0] clamp_q15(longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// Q2.15 times Q0.15, rounded half up back to Q15 and saturated
	function automatic logic [15:0] scale_q15(int pos, int s);
		longint prod;
		prod = longint'(pos) * longint'(s);
		return clamp_q15((prod + 64'sd16384) >>> 15);
	endfunction

	function automatic int step_pos(int pos, int step);
		int v;
		v = pos + step;
		return (v > int'(POS_MAX)) ? int'(POS_MAX) : v;
	endfunction

	// zero counts act as one, oversize ones as the counter span
	function automatic int count_limit(int n);
		if (n == 0)
			return 1;
		return (n > COUNT_CAP) ? COUNT_CAP : n;
	endfunction

	function automatic void rewind_walk();
		col_i     = 0;
		row_i     = 0;
		slice_i   = 0;
		x_pos     = int'(POS_HALF_NEG);
		z_pos     = int'(POS_HALF_NEG);
		phase_acc = angle_start_reg[15:0];
	endfunction

	// Point for one request, then advance column -> row -> slice.
	function automatic void walk_grid(input logic restart_bit, output grid_point_t pt);
		grid_mode_t m;
		logic       col_end, row_end, slice_end;
		m = (mode_reg == MODE_UNUSED) ? MODE_UNIFORM_2D : grid_mode_t'(mode_reg);
		if (restart_bit)
			rewind_walk();
		pt.c = '0;
		case (m)
			MODE_RADIAL_3D: begin
				pt.a = scale_q15(x_pos, sine_at(16'(phase_acc + PHASE_QUARTER)));
				pt.b = scale_q15(x_pos, sine_at(phase_acc));
				pt.c = clamp_q15(longint'(z_pos));
			end
			MODE_RADIAL_2D: begin
				pt.a = scale_q15(x_pos, sine_at(phase_acc));
				pt.b = scale_q15(x_pos, sine_at(16'(phase_acc + PHASE_QUARTER)));
			end
			default: begin
				pt.a = clamp_q15(longint'(x_pos));
				pt.b = clamp_q15(longint'(z_pos));
			end
		endcase
		// an index already past a lowered count also counts as at its end
		col_end   = col_i + 1 >= count_limit(columns_reg);
		row_end   = (m == MODE_RADIAL_2D) || (row_i + 1 >= count_limit(rows_reg));
		slice_end = (m == MODE_UNIFORM_2D) || (slice_i + 1 >= count_limit(slices_reg));
		pt.last   = col_end && row_end && slice_end;

		if (!col_end) begin
			col_i++;
			x_pos = step_pos(x_pos, step_x_reg);
		end else begin
			col_i = 0;
			x_pos = int'(POS_HALF_NEG);
			if (!row_end) begin
				row_i++;
				z_pos = step_pos(z_pos, step_z_reg);
			end else begin
				row_i = 0;
				z_pos = int'(POS_HALF_NEG);
				if (!slice_end) begin
					slice_i++;
					phase_acc = 16'(phase_acc + angle_step_reg[15:0]);
				end else begin
					// full wrap: angle_start is picked up again here
					slice_i   = 0;
					phase_acc = angle_start_reg[15:0];
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver: changes on the falling edge, holds until accepted
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic nv, nr;
		nv = in_valid;
		nr = restart;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_valid || req_taken) begin
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (requests.size() != 0) begin
				if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 10);   // start a burst of idle cycles
				end else begin
					nv = 1'b1;
					nr = requests.pop_front();
				end
			end
		end
		in_valid <= nv;
		restart  <= nr;
	end

	// ------------------------------------------------------------------
	// Point receiver: random stall bursts, plus two long holds mid-run so
	// the internal queue fills and in_ready drops while requests keep coming
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic nrdy;
		nrdy = 1'b1;
		if (!arst_n) begin
			nrdy = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			nrdy = 1'b0;
		end else if ((holds_done == 0 && points_taken >= 300) ||
				(holds_done == 1 && points_taken >= 900)) begin
			holds_done++;
			hold_left = 59;
			nrdy = 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			nrdy = 1'b0;
		end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
			recv_gap = $urandom_range(0, 10);
			nrdy = 1'b0;
		end
		out_ready <= nrdy;
	end

	// ------------------------------------------------------------------
	// Monitor: predict on request beats, check on point beats
	// ------------------------------------------------------------------
	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, what, $signed(want), $signed(got));
		end
	endtask

	always @(posedge clk) begin
		grid_point_t pt, want;
		req_taken = arst_n && in_valid && in_ready;
		if (req_taken) begin
			walk_grid(restart, pt);
			points_due.push_back(pt);
			requests_open--;
		end
		if (arst_n && out_valid && out_ready) begin
			points_taken++;
			if (points_due.size() == 0) begin
				mismatches++;
				$display("%0t: point beat mismatch, expected none, actual %0d %0d %0d %0b",
					$time, coord_a, coord_b, coord_c, last_point);
			end else begin
				want = points_due.pop_front();
				check_field("coord_a", want.a, coord_a);
				check_field("coord_b", want.b, coord_b);
				check_field("coord_c", want.c, coord_c);
				check_field("last_point", {15'd0, want.last}, {15'd0, last_point});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// register write on the falling edge; the shadow follows at once since
	// nothing is in flight while registers change
	task automatic write_reg(logic [2:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[15:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_GRID_MODE:   mode_reg        = value[1:0];
			CFG_COLUMNS:     columns_reg     = value[12:0];
			CFG_ROWS:        rows_reg        = value[12:0];
			CFG_SLICES:      slices_reg      = value[12:0];
			CFG_STEP_X:      step_x_reg      = value[15:0];
			CFG_STEP_Z:      step_z_reg      = value[15:0];
			CFG_ANGLE_START: angle_start_reg = value[15:0];
			CFG_ANGLE_STEP:  angle_step_reg  = value[15:0];
			default: ;
		endcase
	endtask

	// all eight registers, then back to a rising edge for queueing requests
	task automatic load_grid(logic [1:0] mode, int cols, int rws, int slc,
			int sx, int sz, int a0, int da);
		write_reg(CFG_GRID_MODE, mode);
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rws);
		write_reg(CFG_SLICES, slc);
		write_reg(CFG_STEP_X, sx);
		write_reg(CFG_STEP_Z, sz);
		write_reg(CFG_ANGLE_START, a0);
		write_reg(CFG_ANGLE_STEP, da);
		@(posedge clk);
	endtask

	function automatic void offer(logic r);
		requests.push_back(r);
		requests_open++;
	endfunction

	// mostly walk-on requests so the walk wraps, with a few restarts
	function automatic void queue_requests(int n);
		int pct;
		pct = $urandom_range(0, 8);
		repeat (n) offer($urandom_range(0, 99) < pct);
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (requests_open != 0 || points_due.size() != 0);
	endtask

	// small counts dominate so grids close often
	function automatic int pick_count();
		case ($urandom_range(0, 15))
			0:       return 0;
			1:       return COUNT_CAP;
			2:       return $urandom_range(COUNT_CAP + 1, 8191);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_step();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 1;
			2:       return 65535;   // saturates positions quickly
			3:       return 32768;
			4, 5:    return $urandom_range(4096, 24576);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_phase();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(0, 3) * 16384;   // quadrant borders
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_idle();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
	endfunction

	initial begin
		for (int k = 0; k < TABLE_DEPTH; k++)
			sine_quarter[k] = quarter_sine(k);
		// register values after reset
		mode_reg        = MODE_RADIAL_3D;
		columns_reg     = 1;
		rows_reg        = 1;
		slices_reg      = 1;
		step_x_reg      = 32768;
		step_z_reg      = 32768;
		angle_start_reg = 0;
		angle_step_reg  = 0;
		rewind_walk();

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset values: a one-point grid, flagged last every time
		@(posedge clk);
		offer(1'b1);
		offer(1'b0);
		offer(1'b0);
		wait_drained();

		// radial 3D, 3 x 2 x 2: quadrant-crossing angles and a restart in the
		// middle of the walk
		load_grid(MODE_RADIAL_3D, 3, 2, 2, 16384, 32768, 16'h2000, 16'h4000);
		offer(1'b1);
		repeat (6) offer(1'b0);
		offer(1'b1);
		repeat (5) offer(1'b0);
		wait_drained();

		for (int ph = 0; ph < 15; ph++) begin
			case (ph)
				// everything at the top: unused mode, oversize counts,
				// saturating steps
				0: load_grid(MODE_UNUSED, 8191, 8191, 8191, 65535, 65535, 65535, 65535);
				// everything at the bottom: zero counts and steps
				1: load_grid(MODE_RADIAL_3D, 0, 0, 0, 0, 0, 0, 0);
				2: load_grid(MODE_RADIAL_2D, 3, 8191, 4, 65535, 1, 16'hC000, 16'h8000);
				3: load_grid(MODE_RADIAL_3D, 2, 3, 4, 65535, 65535, 65535, 16'h3000);
				default: load_grid(MODE_CODES[$urandom_range(0, 3)], pick_count(),
					pick_count(), pick_count(), pick_step(), pick_step(),
					pick_phase(), pick_phase());
			endcase
			send_idle_pct = pick_idle();
			recv_idle_pct = pick_idle();
			queue_requests($urandom_range(60, 120));
			wait_drained();
		end

		// closing stretch at full rate on both sides
		load_grid(MODE_CODES[$urandom_range(0, 3)], $urandom_range(1, 4),
			$urandom_range(1, 4), $urandom_range(1, 4), pick_step(), pick_step(),
			pick_phase(), pick_phase());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_requests(80);
		wait_drained();

		// let the block run on idle after the drain to catch stray beats
		repeat (2 * MAX_IN_FLIGHT) @(negedge clk);
		if (mismatches == 0 && points_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
